[design/tcw_pkg.sv]
// Shared types and constants for the text console writer.
// No dependencies; the top level and the testbench refer to it by scoped names.
package tcw_pkg;

   // Default screen geometry
   localparam int DEFAULT_COLUMNS = 80;
   localparam int DEFAULT_ROWS    = 25;

   // Operation codes
   localparam logic [1:0] OP_PUT   = 2'd0;
   localparam logic [1:0] OP_BACK  = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;
   localparam logic [1:0] OP_READ  = 2'd3;

   // Register indexes on the configuration port
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 8;
   localparam logic [CSR_INDEX_W-1:0] CSR_FOREGROUND = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BACKGROUND = 2'd1;

   // Character and attribute codes
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_TAB     = 8'h09;
   localparam logic [7:0] CHAR_BLANK   = 8'h20;
   localparam logic [3:0] RESET_FG     = 4'hF;
   localparam logic [3:0] RESET_BG     = 4'h0;
   localparam logic [7:0] RESET_ATTR   = 8'h0F;

   localparam int CELL_W = 16;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [7:0]  char_code;
      logic [10:0] cell_index;
   } req_type;

   typedef struct packed {
      logic [4:0]  cursor_row;
      logic [6:0]  cursor_col;
      logic [10:0] cursor_position;
      logic [15:0] cell_data;
   } rsp_type;

endpackage

[design/text_console_writer.sv]
// Text console writer: a screen store of ROWS x COLUMNS 16-bit cells and a cursor.
// Uses tcw_pkg and tcw_ram.
//
// Usage: an item on req_ (req_valid/req_stall, req_data) runs one operation:
// put character (newline, tab, printable), backspace, clear screen or read cell.
// Every item gives exactly one result on rsp_ (rsp_valid/rsp_stall, rsp_data)
// with the cursor after the operation and, for a read, the cell value.
// Colors are to be written on csr_ (csr_valid/csr_ready, csr_index, csr_data)
// while idle, which the block itself leaves unenforced. A put, newline, tab or
// backspace goes from acceptance through ST_RESP into the output register; a read
// first passes ST_READ for the registered RAM read. The next item is taken once
// the result is loaded. A scroll first blanks the new bottom row (the screen rotates
// through a row base register, so no rows are copied) and a clear blanks every
// cell, both through the single RAM write port, one cell per cycle.
// Reset: the cursor goes to 0,0, colors to white on black, and a clearing pass
// writes 0x0F20 into every cell; req_stall stays high meanwhile, csr_ writes
// are still taken. A stalled result is held in the output register; the block
// takes the next item but holds its own result until the register is free.
module text_console_writer #(
   parameter int COLUMNS = tcw_pkg::DEFAULT_COLUMNS,
   parameter int ROWS    = tcw_pkg::DEFAULT_ROWS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  tcw_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output tcw_pkg::rsp_type                    rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [tcw_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [tcw_pkg::CSR_DATA_W-1:0]      csr_data
);

   localparam int CELLS  = ROWS * COLUMNS;
   localparam int ADDR_W = $clog2(CELLS);
   localparam int ROW_W  = $clog2(ROWS);
   localparam int COL_W  = $clog2(COLUMNS);
   localparam int CW     = tcw_pkg::CELL_W;

   localparam logic [ADDR_W-1:0] LAST_ROW_BASE = ADDR_W'((ROWS - 1) * COLUMNS);
   localparam logic [ADDR_W-1:0] LAST_CELL     = ADDR_W'(CELLS - 1);
   localparam logic [ADDR_W-1:0] COLS_A        = ADDR_W'(COLUMNS);
   localparam logic [ADDR_W-1:0] COLS_M1_A     = ADDR_W'(COLUMNS - 1);
   localparam logic [COL_W-1:0]  LAST_COL      = COL_W'(COLUMNS - 1);
   localparam logic [ROW_W-1:0]  LAST_ROW      = ROW_W'(ROWS - 1);

   typedef enum logic [3:0] {
      ST_SWEEP = 4'b0001,
      ST_IDLE  = 4'b0010,
      ST_READ  = 4'b0100,
      ST_RESP  = 4'b1000
   } state_type;

   state_type          state_ff, state_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic [COL_W-1:0]   col_ff, col_in;
   logic [ADDR_W-1:0]  lin_ff, lin_in;
   logic [ADDR_W-1:0]  base_ff, base_in;
   logic [ADDR_W-1:0]  sweep_addr_ff, sweep_addr_in;
   logic [ADDR_W-1:0]  sweep_last_ff, sweep_last_in;
   logic [CW-1:0]      fill_ff, fill_in;
   logic               sweep_rsp_ff, sweep_rsp_in;
   logic               idx_ok_ff, idx_ok_in;
   logic [CW-1:0]      cell_data_ff, cell_data_in;
   logic               rsp_valid_ff, rsp_valid_in;
   tcw_pkg::rsp_type   rsp_data_ff, rsp_data_in;
   logic [3:0]         fg_ff, fg_in;
   logic [3:0]         bg_ff, bg_in;

   logic               accept;
   logic               wr_en;
   logic [ADDR_W-1:0]  wr_addr;
   logic [CW-1:0]      wr_data;
   logic               rd_en;
   logic [ADDR_W-1:0]  rd_addr;
   logic [CW-1:0]      rd_data;
   logic [CW-1:0]      blank_cell;
   logic [COL_W:0]     tab_sum;
   logic [COL_W:0]     tab_col;
   logic [ADDR_W:0]    base_step;

   // Map a logical cell position onto the rotated screen store
   function automatic logic [ADDR_W-1:0] phys_addr(input logic [ADDR_W-1:0] pos,
                                                   input logic [ADDR_W-1:0] base);
      logic [ADDR_W:0] sum;
      sum = {1'b0, pos} + {1'b0, base};
      if (sum >= (ADDR_W + 1)'(CELLS)) begin
         sum = sum - (ADDR_W + 1)'(CELLS);
      end
      return sum[ADDR_W-1:0];
   endfunction

   tcw_ram #(
      .WIDTH (CW),
      .DEPTH (CELLS)
   ) u_screen (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_stall  = (state_ff != ST_IDLE);
   assign accept     = req_valid && !req_stall;
   assign csr_ready  = 1'b1;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;
   assign blank_cell = {bg_ff, fg_ff, tcw_pkg::CHAR_BLANK};
   assign rd_addr    = phys_addr(ADDR_W'(req_data.cell_index), base_ff);

   // Tab target: next multiple of four
   assign tab_sum    = {1'b0, col_ff} + (COL_W + 1)'(4);
   assign tab_col    = {tab_sum[COL_W:2], 2'b00};
   assign base_step  = {1'b0, base_ff} + {1'b0, COLS_A};

   // Decode color register writes
   always_comb begin
      fg_in = fg_ff;
      bg_in = bg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            tcw_pkg::CSR_FOREGROUND: fg_in = csr_data[3:0];
            tcw_pkg::CSR_BACKGROUND: bg_in = csr_data[3:0];
            default: ;
         endcase
      end
   end

   // Sequence the operations and drive the RAM ports
   always_comb begin
      logic line_feed;
      line_feed     = 1'b0;
      state_in      = state_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      lin_in        = lin_ff;
      base_in       = base_ff;
      sweep_addr_in = sweep_addr_ff;
      sweep_last_in = sweep_last_ff;
      fill_in       = fill_ff;
      sweep_rsp_in  = sweep_rsp_ff;
      idx_ok_in     = idx_ok_ff;
      cell_data_in  = cell_data_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      wr_en         = 1'b0;
      wr_addr       = '0;
      wr_data       = '0;
      rd_en         = 1'b0;

      // Drop the result once the receiver takes it
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_SWEEP: begin
            wr_en   = 1'b1;
            wr_addr = sweep_addr_ff;
            wr_data = fill_ff;
            if (sweep_addr_ff == sweep_last_ff) begin
               state_in = sweep_rsp_ff ? ST_RESP : ST_IDLE;
            end else begin
               sweep_addr_in = sweep_addr_ff + ADDR_W'(1);
            end
         end
         ST_IDLE: begin
            if (accept) begin
               cell_data_in = '0;
               state_in     = ST_RESP;
               case (req_data.opcode)
                  tcw_pkg::OP_PUT: begin
                     if (req_data.char_code == tcw_pkg::CHAR_NEWLINE) begin
                        line_feed = 1'b1;
                     end else if (req_data.char_code == tcw_pkg::CHAR_TAB) begin
                        if (tab_col >= (COL_W + 1)'(COLUMNS)) begin
                           line_feed = 1'b1;
                        end else begin
                           col_in = tab_col[COL_W-1:0];
                           lin_in = lin_ff - ADDR_W'(col_ff) + ADDR_W'(tab_col);
                        end
                     end else begin
                        wr_en   = 1'b1;
                        wr_addr = phys_addr(lin_ff, base_ff);
                        wr_data = {bg_ff, fg_ff, req_data.char_code};
                        if (col_ff == LAST_COL) begin
                           line_feed = 1'b1;
                        end else begin
                           col_in = col_ff + COL_W'(1);
                           lin_in = lin_ff + ADDR_W'(1);
                        end
                     end
                     // Advance to the next line, scrolling from the bottom row
                     if (line_feed) begin
                        col_in = '0;
                        if (row_ff == LAST_ROW) begin
                           lin_in        = LAST_ROW_BASE;
                           sweep_addr_in = base_ff;
                           sweep_last_in = base_ff + COLS_M1_A;
                           fill_in       = blank_cell;
                           sweep_rsp_in  = 1'b1;
                           base_in       = (base_step == (ADDR_W + 1)'(CELLS)) ?
                                           '0 : base_step[ADDR_W-1:0];
                           state_in      = ST_SWEEP;
                        end else begin
                           row_in = row_ff + ROW_W'(1);
                           lin_in = lin_ff - ADDR_W'(col_ff) + COLS_A;
                        end
                     end
                  end
                  tcw_pkg::OP_BACK: begin
                     if (col_ff != '0 || row_ff != '0) begin
                        lin_in  = lin_ff - ADDR_W'(1);
                        wr_en   = 1'b1;
                        wr_addr = phys_addr(lin_ff - ADDR_W'(1), base_ff);
                        wr_data = blank_cell;
                        if (col_ff != '0) begin
                           col_in = col_ff - COL_W'(1);
                        end else begin
                           row_in = row_ff - ROW_W'(1);
                           col_in = LAST_COL;
                        end
                     end
                  end
                  tcw_pkg::OP_CLEAR: begin
                     row_in        = '0;
                     col_in        = '0;
                     lin_in        = '0;
                     base_in       = '0;
                     sweep_addr_in = '0;
                     sweep_last_in = LAST_CELL;
                     fill_in       = blank_cell;
                     sweep_rsp_in  = 1'b1;
                     state_in      = ST_SWEEP;
                  end
                  default: begin
                     rd_en     = 1'b1;
                     idx_ok_in = (32'(req_data.cell_index) < 32'(CELLS));
                     state_in  = ST_READ;
                  end
               endcase
            end
         end
         ST_READ: begin
            cell_data_in = idx_ok_ff ? rd_data : '0;
            state_in     = ST_RESP;
         end
         ST_RESP: begin
            // Hold until the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in                = 1'b1;
               rsp_data_in.cursor_row      = 5'(row_ff);
               rsp_data_in.cursor_col      = 7'(col_ff);
               rsp_data_in.cursor_position = 11'(lin_ff);
               rsp_data_in.cell_data       = cell_data_ff;
               state_in                    = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_SWEEP;
         row_ff        <= '0;
         col_ff        <= '0;
         lin_ff        <= '0;
         base_ff       <= '0;
         sweep_addr_ff <= '0;
         sweep_last_ff <= LAST_CELL;
         fill_ff       <= {tcw_pkg::RESET_ATTR, tcw_pkg::CHAR_BLANK};
         sweep_rsp_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         fg_ff         <= tcw_pkg::RESET_FG;
         bg_ff         <= tcw_pkg::RESET_BG;
      end else begin
         state_ff      <= state_in;
         row_ff        <= row_in;
         col_ff        <= col_in;
         lin_ff        <= lin_in;
         base_ff       <= base_in;
         sweep_addr_ff <= sweep_addr_in;
         sweep_last_ff <= sweep_last_in;
         fill_ff       <= fill_in;
         sweep_rsp_ff  <= sweep_rsp_in;
         rsp_valid_ff  <= rsp_valid_in;
         fg_ff         <= fg_in;
         bg_ff         <= bg_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      idx_ok_ff    <= idx_ok_in;
      cell_data_ff <= cell_data_in;
      rsp_data_ff  <= rsp_data_in;
   end

endmodule

[design/tcw_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing; contents are undefined until written.
module tcw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write one word, read one word into the registered rd_data output
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

[bench/tb_text_console_writer.sv]
// Self-checking testbench for text_console_writer: a screen and cursor tracker
// predicts every result; plain tasks drive the item and color ports, a process the result stall.
// Depends on tcw_pkg and the text_console_writer RTL.
module tb_text_console_writer;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int COLUMNS = tcw_pkg::DEFAULT_COLUMNS;
   localparam int ROWS    = tcw_pkg::DEFAULT_ROWS;
   localparam int CELLS   = COLUMNS * ROWS;
   // Indexes the block does not decode; writes to them must change nothing
   localparam logic [tcw_pkg::CSR_INDEX_W-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [tcw_pkg::CSR_INDEX_W-1:0] CSR_SPARE_B = 2'd3;
   // Quiet time after the last result: long enough for a full clearing pass
   localparam int SETTLE_CYCLES   = CELLS + 100;
   localparam int PHASE_ITEMS     = 76;

   // Mirror of the screen store, cursor and colors; checks results in order
   class console_tracker;
      logic [15:0]       screen [0:CELLS-1];
      int unsigned       row, col;
      logic [3:0]        fg, bg;
      tcw_pkg::rsp_type  pending_rsp [$];
      int                errors;
      int                ops [4];
      int                scrolls;
      int                color_writes;

      function new();
         for (int i = 0; i < CELLS; i++) begin
            screen[i] = {tcw_pkg::RESET_ATTR, tcw_pkg::CHAR_BLANK};
         end
         row = 0;
         col = 0;
         fg = tcw_pkg::RESET_FG;
         bg = tcw_pkg::RESET_BG;
      endfunction

      function logic [15:0] colored(logic [7:0] ch);
         return {bg, fg, ch};
      endfunction

      function void note_color_write(logic [tcw_pkg::CSR_INDEX_W-1:0] idx,
                                     logic [tcw_pkg::CSR_DATA_W-1:0] data);
         color_writes++;
         if (idx == tcw_pkg::CSR_FOREGROUND) fg = data[3:0];
         else if (idx == tcw_pkg::CSR_BACKGROUND) bg = data[3:0];
      endfunction

      // Advance one row; past the bottom, shift the screen up and blank the last row
      function void next_row();
         row++;
         if (row >= ROWS) begin
            for (int i = 0; i < (ROWS - 1) * COLUMNS; i++) screen[i] = screen[i + COLUMNS];
            for (int i = (ROWS - 1) * COLUMNS; i < CELLS; i++) begin
               screen[i] = colored(tcw_pkg::CHAR_BLANK);
            end
            row = ROWS - 1;
            scrolls++;
         end
      endfunction

      // Apply one accepted item and queue the result it must produce
      function void take_item(tcw_pkg::req_type it);
         logic [15:0]       data;
         tcw_pkg::rsp_type  want;
         data = '0;
         ops[it.opcode]++;
         case (it.opcode)
            tcw_pkg::OP_PUT: begin
               if (it.char_code == tcw_pkg::CHAR_NEWLINE) begin
                  col = 0;
                  next_row();
               end else if (it.char_code == tcw_pkg::CHAR_TAB) begin
                  col = (col + 4) & ~32'd3;
                  if (col >= COLUMNS) begin
                     col = 0;
                     next_row();
                  end
               end else begin
                  screen[row * COLUMNS + col] = colored(it.char_code);
                  col++;
                  if (col >= COLUMNS) begin
                     col = 0;
                     next_row();
                  end
               end
            end
            tcw_pkg::OP_BACK: begin
               // top-left cell: nothing moves and nothing is blanked
               if (col > 0 || row > 0) begin
                  if (col > 0) begin
                     col--;
                  end else begin
                     row--;
                     col = COLUMNS - 1;
                  end
                  screen[row * COLUMNS + col] = colored(tcw_pkg::CHAR_BLANK);
               end
            end
            tcw_pkg::OP_CLEAR: begin
               for (int i = 0; i < CELLS; i++) screen[i] = colored(tcw_pkg::CHAR_BLANK);
               row = 0;
               col = 0;
            end
            default: begin
               if (it.cell_index < CELLS) data = screen[it.cell_index];
            end
         endcase
         want.cursor_row      = row[4:0];
         want.cursor_col      = col[6:0];
         want.cursor_position = 11'(row * COLUMNS + col);
         want.cell_data       = data;
         pending_rsp.push_back(want);
      endfunction

      function void check_field(string what, int unsigned want, int unsigned got);
         if (want != got) begin
            errors++;
            $display("%0t: %s mismatch: expected %0d (0x%0h), actual %0d (0x%0h)",
                     $time, what, want, want, got, got);
         end
      endfunction

      function void check_rsp(tcw_pkg::rsp_type got);
         tcw_pkg::rsp_type want;
         if (pending_rsp.size() == 0) begin
            errors++;
            $display("%0t: unexpected result: expected none, actual %h", $time, got);
            return;
         end
         want = pending_rsp.pop_front();
         check_field("cursor_row", want.cursor_row, got.cursor_row);
         check_field("cursor_col", want.cursor_col, got.cursor_col);
         check_field("cursor_position", want.cursor_position, got.cursor_position);
         check_field("cell_data", want.cell_data, got.cell_data);
      endfunction
   endclass

   logic                            clock;
   logic                            reset;
   logic                            req_valid;
   logic                            req_stall;
   tcw_pkg::req_type                req_data;
   logic                            rsp_valid;
   logic                            rsp_stall;
   tcw_pkg::rsp_type                rsp_data;
   logic                            csr_valid;
   logic                            csr_ready;
   logic [tcw_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [tcw_pkg::CSR_DATA_W-1:0]  csr_data;

   console_tracker console;
   bit             idle_on;

   text_console_writer uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Hard stop in case the block hangs
   initial begin
      #60_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   // Check every result taken on the rsp_ side
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) console.check_rsp(rsp_data);
   end

   // Hold off results in random bursts while idling is enabled
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 16)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // Offer one item, with an optional gap ahead of it; note it once taken
   task automatic send_item(input tcw_pkg::req_type it);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= it;
      do @(posedge clock); while (req_stall);
      console.take_item(it);
   endtask

   task automatic send_op(input logic [1:0] op, input logic [7:0] ch, input logic [10:0] idx);
      tcw_pkg::req_type it;
      it.opcode     = op;
      it.char_code  = ch;
      it.cell_index = idx;
      send_item(it);
   endtask

   // Write one register; valid stays high so writes can go back to back
   task automatic write_csr(input logic [tcw_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [3:0] val);
      logic [tcw_pkg::CSR_DATA_W-1:0] data;
      data      = {4'($urandom_range(0, 15)), val};
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      console.note_color_write(idx, data);
   endtask

   // Stop sending, wait for every result, then let any blanking pass finish
   task automatic drain();
      req_valid <= 1'b0;
      while (console.pending_rsp.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Mostly text with line breaks, some edits and reads, rare clears
   function automatic tcw_pkg::req_type random_item();
      tcw_pkg::req_type it;
      int               pick;
      it.opcode     = tcw_pkg::OP_PUT;
      it.char_code  = 8'($urandom_range(32, 126));
      it.cell_index = 11'($urandom_range(0, 2047));
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
         it.opcode = tcw_pkg::OP_PUT;
      end else if (pick < 70) begin
         it.char_code = tcw_pkg::CHAR_NEWLINE;
      end else if (pick < 75) begin
         it.char_code = tcw_pkg::CHAR_TAB;
      end else if (pick < 79) begin
         it.char_code = 8'($urandom_range(0, 255));
      end else if (pick < 88) begin
         it.opcode = tcw_pkg::OP_BACK;
      end else if (pick < 99) begin
         it.opcode = tcw_pkg::OP_READ;
         // favor the cursor's neighborhood, where cells were just written
         if ($urandom_range(0, 1) == 0)
            it.cell_index = 11'(console.row * COLUMNS + $urandom_range(0, COLUMNS - 1));
      end else begin
         it.opcode = tcw_pkg::OP_CLEAR;
      end
      return it;
   endfunction

   initial begin
      logic [3:0] fg_set [5];
      logic [3:0] bg_set [5];

      console   = new();
      idle_on   = 1'b1;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      csr_valid = 1'b0;
      csr_index = tcw_pkg::CSR_FOREGROUND;
      csr_data  = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Undecoded indexes first, then the reset colors written explicitly
      write_csr(CSR_SPARE_A, 4'($urandom_range(0, 15)));
      write_csr(CSR_SPARE_B, 4'($urandom_range(0, 15)));
      write_csr(tcw_pkg::CSR_FOREGROUND, tcw_pkg::RESET_FG);
      write_csr(tcw_pkg::CSR_BACKGROUND, tcw_pkg::RESET_BG);
      csr_valid <= 1'b0;

      // Directed: edge characters, tab, newline, backspace across lines
      send_op(tcw_pkg::OP_BACK, tcw_pkg::CHAR_BLANK, 11'd0);   // at the top-left cell
      send_op(tcw_pkg::OP_READ, 8'h00, 11'd0);
      send_op(tcw_pkg::OP_PUT, 8'h00, 11'd2047);
      send_op(tcw_pkg::OP_PUT, 8'hFF, 11'd0);
      send_op(tcw_pkg::OP_PUT, "A", 11'd0);
      send_op(tcw_pkg::OP_PUT, tcw_pkg::CHAR_TAB, 11'd0);
      send_op(tcw_pkg::OP_PUT, tcw_pkg::CHAR_NEWLINE, 11'd0);
      send_op(tcw_pkg::OP_BACK, 8'h00, 11'd0);     // column zero: back to the last column
      send_op(tcw_pkg::OP_PUT, "Z", 11'd0);        // last column: wrap
      send_op(tcw_pkg::OP_BACK, 8'h00, 11'd0);
      send_op(tcw_pkg::OP_PUT, tcw_pkg::CHAR_TAB, 11'd0);   // tab past the edge wraps
      send_op(tcw_pkg::OP_READ, 8'hFF, 11'(COLUMNS - 1));
      send_op(tcw_pkg::OP_READ, 8'h00, 11'd1);
      send_op(tcw_pkg::OP_READ, 8'h00, 11'(CELLS - 1));
      send_op(tcw_pkg::OP_READ, 8'h00, 11'(CELLS));   // first index out of range
      send_op(tcw_pkg::OP_READ, 8'h00, 11'd2047);
      send_op(tcw_pkg::OP_CLEAR, 8'h00, 11'd0);
      send_op(tcw_pkg::OP_READ, 8'h00, 11'd0);
      send_op(tcw_pkg::OP_PUT, tcw_pkg::CHAR_BLANK, 11'd0);
      send_op(tcw_pkg::OP_PUT, tcw_pkg::CHAR_NEWLINE, 11'd0);

      // Random phases, each under new colors; the last one without idling
      fg_set = '{4'h0, 4'hF, 4'h0, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15))};
      bg_set = '{4'hF, 4'hF, 4'h0, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15))};
      for (int p = 0; p < 5; p++) begin
         drain();
         write_csr(tcw_pkg::CSR_FOREGROUND, fg_set[p]);
         write_csr(tcw_pkg::CSR_BACKGROUND, bg_set[p]);
         csr_valid <= 1'b0;
         if (p == 4) idle_on = 1'b0;
         for (int n = 0; n < PHASE_ITEMS; n++) send_item(random_item());
      end
      drain();

      $display("Ran %0d puts, %0d backspaces, %0d clears and %0d reads;",
               console.ops[tcw_pkg::OP_PUT], console.ops[tcw_pkg::OP_BACK],
               console.ops[tcw_pkg::OP_CLEAR], console.ops[tcw_pkg::OP_READ]);
      $display("the screen scrolled %0d times across %0d color register writes.",
               console.scrolls, console.color_writes);
      if (console.errors == 0 && console.pending_rsp.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule
